### sv/lbc_pkg.sv
`timescale 1ns / 1ps
package lbc_pkg;
    localparam int ENTRIES     = 256;
    localparam int BLOCK_WORDS = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int WPOS_W      = $clog2(BLOCK_WORDS + 1);
    localparam int WIDX_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int DISK_LIMIT  = 16;
    localparam int BLOCK_LIMIT = 256;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_DUP   = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_STREAM,
        S_BEAT,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  disk;
        logic [8:0]  block;
        logic [63:0] data_word;
        logic        word_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_word;
        logic        result_last;
        logic [31:0] query_count;
        logic [31:0] hit_count;
    } out_item_t;

    // scan results handed from the tag walker to the controller
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] lru_idx;
    } scan_res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction
endpackage

### sv/lbc_tag_scan.sv
`timescale 1ns / 1ps
module lbc_tag_scan (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lbc_pkg::CNT_W-1:0]  count,
    input  logic [3:0]                 tag_disk,
    input  logic [7:0]                 tag_block,
    input  logic                       tag_ok,
    input  logic                       wr_en,
    input  logic [lbc_pkg::IDX_W-1:0]  wr_idx,
    input  logic                       wr_tag,
    input  logic [31:0]                wr_stamp,
    output logic                       done,
    output lbc_pkg::scan_res_t         res
);
    import lbc_pkg::*;

    logic             valid_reg [ENTRIES];
    logic [3:0]       disk_mem  [ENTRIES];
    logic [7:0]       block_mem [ENTRIES];
    logic [31:0]      stamp_mem [ENTRIES];

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_valid_reg;
    logic [3:0]       rd_disk_reg;
    logic [7:0]       rd_block_reg;
    logic [31:0]      rd_stamp_reg;
    logic             first_reg;
    logic [31:0]      best_reg;
    scan_res_t        res_reg;
    logic             done_reg;

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (start) begin
            busy_next = 1'b1;
            pos_next  = '0;
        end else if (busy_reg) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == count - 1'b1) busy_next = 1'b0;
        end
    end

    // valid bits cleared at reset; tag/stamp arrays read one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) valid_reg[i] <= 1'b0;
            busy_reg   <= 1'b0;
            pos_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            pos_reg    <= pos_next;
            rd_vld_reg <= busy_reg;
            done_reg   <= rd_vld_reg && !busy_reg;
            if (wr_en && wr_tag) valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stamp_mem[wr_idx] <= wr_stamp;
            if (wr_tag) begin
                disk_mem[wr_idx]  <= tag_disk;
                block_mem[wr_idx] <= tag_block;
            end
        end
        rd_idx_reg   <= pos_reg[IDX_W-1:0];
        rd_valid_reg <= valid_reg[pos_reg[IDX_W-1:0]];
        rd_disk_reg  <= disk_mem[pos_reg[IDX_W-1:0]];
        rd_block_reg <= block_mem[pos_reg[IDX_W-1:0]];
        rd_stamp_reg <= stamp_mem[pos_reg[IDX_W-1:0]];
    end

    // one shared compare per cycle over the registered entry
    always_ff @(posedge aclk) begin
        if (start) begin
            res_reg   <= '0;
            first_reg <= 1'b1;
            best_reg  <= '0;
        end else if (rd_vld_reg) begin
            first_reg <= 1'b0;
            if (rd_valid_reg && tag_ok && rd_disk_reg == tag_disk
                && rd_block_reg == tag_block && !res_reg.hit) begin
                res_reg.hit     <= 1'b1;
                res_reg.hit_idx <= rd_idx_reg;
            end
            if (!rd_valid_reg && !res_reg.free) begin
                res_reg.free     <= 1'b1;
                res_reg.free_idx <= rd_idx_reg;
            end
            // unstamped invalid entries also carry stamps; model uses all stamps
            if (first_reg || rd_stamp_reg < best_reg) begin
                best_reg        <= rd_stamp_reg;
                res_reg.lru_idx <= rd_idx_reg;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg) else $error("scan done while busy");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pos_reg < count) else $error("scan past count");
    a_one_shot: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held");
endmodule

### sv/lbc_data_ram.sv
`timescale 1ns / 1ps
module lbc_data_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

### sv/lru_block_cache.sv
`timescale 1ns / 1ps
// Lookup/update/insert each walk the first entries_in_use entries, one per cycle.
// A hit then streams BLOCK_WORDS words, each a RAM read followed by the result
// register, and holds while the result is not taken; a transfer writes one beat in
// S_REPLY and takes the next in S_BEAT, after the walk.
// The tag walker's single compare sets throughput.
// Reset (aresetn low, synchronous) clears valid bits, counters, tick and control;
// data words are not cleared and need no clearing pass.
module lru_block_cache (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lbc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lbc_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import lbc_pkg::*;

    localparam int ADDR_W = $clog2(ENTRIES * BLOCK_WORDS);

    state_t state_reg, state_next;
    logic [8:0]  cfg_reg;
    logic [CNT_W-1:0] count;
    logic [1:0]  cmd_reg, cmd_next;
    logic [3:0]  disk_reg, disk_next;
    logic [7:0]  blk_reg, blk_next;
    logic        range_ok_reg, range_ok_next;
    logic [63:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        writing_reg, writing_next;
    logic [1:0]  pend_reg, pend_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [WPOS_W-1:0] wpos_reg, wpos_next;
    logic [31:0] tick_reg, tick_next, qcnt_reg, qcnt_next, hcnt_reg, hcnt_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;
    logic [WPOS_W-1:0] rpos_reg, rpos_next;
    logic        rd_pend_reg, rd_pend_next;

    logic        scan_start, scan_done;
    scan_res_t   sres;
    logic        tw_en, tw_tag;
    logic [IDX_W-1:0] tw_idx;
    logic        ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [63:0] ram_rdata;

    assign count = (cfg_reg < 9'd2) ? CNT_W'(2) :
                   (32'(cfg_reg) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(cfg_reg);
    assign cfg_ready = 1'b1;

    lbc_tag_scan u_scan (
        .aclk, .aresetn, .start(scan_start), .count,
        .tag_disk(disk_reg), .tag_block(blk_reg), .tag_ok(range_ok_reg),
        .wr_en(tw_en), .wr_idx(tw_idx), .wr_tag(tw_tag), .wr_stamp(tick_next),
        .done(scan_done), .res(sres)
    );

    lbc_data_ram #(.DEPTH(ENTRIES * BLOCK_WORDS), .WIDTH(64)) u_ram (
        .aclk, .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(word_reg),
        .rd_addr(ram_raddr), .rd_data(ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE || state_reg == S_BEAT) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign ram_waddr = ADDR_W'({slot_reg, wpos_reg[WIDX_W-1:0]});
    assign ram_raddr = ADDR_W'({sres.hit_idx, rpos_reg[WIDX_W-1:0]});

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg; disk_next = disk_reg; blk_next = blk_reg;
        range_ok_next = range_ok_reg; word_next = word_reg; last_next = last_reg;
        writing_next = writing_reg; pend_next = pend_reg; slot_next = slot_reg;
        wpos_next = wpos_reg; tick_next = tick_reg; qcnt_next = qcnt_reg;
        hcnt_next = hcnt_reg; m_valid_next = m_valid_reg; m_data_next = m_data_reg;
        rpos_next = rpos_reg; rd_pend_next = 1'b0;
        scan_start = 1'b0; tw_en = 1'b0; tw_tag = 1'b0; tw_idx = slot_reg;
        ram_we = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && s_data.cmd != CMD_NONE) begin
                    cmd_next  = s_data.cmd;
                    disk_next = s_data.disk[3:0];
                    blk_next  = s_data.block[7:0];
                    range_ok_next = (32'(s_data.disk) < DISK_LIMIT)
                                 && (32'(s_data.block) < BLOCK_LIMIT);
                    word_next = s_data.data_word;
                    last_next = s_data.word_last;
                    wpos_next = '0;
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: if (scan_done) state_next = S_DECIDE;
            S_DECIDE: begin
                state_next = S_REPLY;
                case (cmd_reg)
                    CMD_LOOKUP: begin
                        qcnt_next = sat_inc(qcnt_reg);
                        if (sres.hit) begin
                            hcnt_next = sat_inc(hcnt_reg);
                            tick_next = sat_inc(tick_reg);
                            tw_en = 1'b1; tw_idx = sres.hit_idx;
                            rpos_next = '0;
                            state_next = S_STREAM;
                        end else begin
                            pend_next = ST_MISS;
                        end
                    end
                    CMD_UPDATE: begin
                        writing_next = sres.hit;
                        pend_next = sres.hit ? ST_OK : ST_MISS;
                        if (sres.hit) begin
                            slot_next = sres.hit_idx;
                            tick_next = sat_inc(tick_reg);
                            tw_en = 1'b1; tw_tag = 1'b1; tw_idx = sres.hit_idx;
                        end
                    end
                    default: begin
                        if (!range_ok_reg) begin
                            writing_next = 1'b0; pend_next = ST_RANGE;
                        end else if (sres.hit) begin
                            writing_next = 1'b0; pend_next = ST_DUP;
                        end else begin
                            writing_next = 1'b1; pend_next = ST_OK;
                            slot_next = sres.free ? sres.free_idx : sres.lru_idx;
                            tick_next = sat_inc(tick_reg);
                            tw_en = 1'b1; tw_tag = 1'b1; tw_idx = slot_next;
                        end
                    end
                endcase
                if (cmd_reg != CMD_LOOKUP) state_next = S_REPLY;
            end
            S_REPLY: begin
                // each transfer beat (last held), or a lookup's miss result
                if (cmd_reg == CMD_LOOKUP) begin
                    if (!m_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next = '{ST_MISS, 64'd0, 1'b1, qcnt_reg, hcnt_reg};
                        state_next = S_IDLE;
                    end
                end else begin
                    if (writing_reg && 32'(wpos_reg) < BLOCK_WORDS) ram_we = 1'b1;
                    if (32'(wpos_reg) < BLOCK_WORDS) wpos_next = wpos_reg + 1'b1;
                    if (last_reg) begin
                        if (!m_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next = '{writing_reg ? ST_OK : pend_reg, 64'd0,
                                            1'b1, qcnt_reg, hcnt_reg};
                            state_next = S_IDLE;
                        end else begin
                            ram_we = 1'b0; wpos_next = wpos_reg;
                        end
                    end else begin
                        state_next = S_BEAT;
                    end
                end
            end
            S_BEAT: begin
                if (s_valid && s_ready) begin
                    word_next = s_data.data_word;
                    last_next = s_data.word_last;
                    state_next = S_REPLY;
                end
            end
            S_STREAM: begin
                // ram read issued this cycle, data registered next cycle
                if (rd_pend_reg && (!m_valid_reg || m_ready)) begin
                    m_valid_next = 1'b1;
                    m_data_next = '{ST_OK, ram_rdata,
                                    32'(rpos_reg) == BLOCK_WORDS, qcnt_reg, hcnt_reg};
                    if (32'(rpos_reg) == BLOCK_WORDS) state_next = S_IDLE;
                end else if (!rd_pend_reg && (!m_valid_reg || m_ready)) begin
                    rd_pend_next = 1'b1;
                    rpos_next = rpos_reg + 1'b1;
                end else begin
                    rd_pend_next = rd_pend_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cfg_reg <= 9'd256;
            tick_reg <= '0; qcnt_reg <= '0; hcnt_reg <= '0;
            m_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            wpos_reg <= '0; rpos_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) cfg_reg <= cfg_data;
            tick_reg <= tick_next; qcnt_reg <= qcnt_next; hcnt_reg <= hcnt_next;
            m_valid_reg <= m_valid_next;
            rd_pend_reg <= rd_pend_next;
            wpos_reg <= wpos_next; rpos_reg <= rpos_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next; disk_reg <= disk_next; blk_reg <= blk_next;
        range_ok_reg <= range_ok_next; word_reg <= word_next; last_reg <= last_next;
        writing_reg <= writing_next; pend_reg <= pend_next; slot_reg <= slot_next;
        m_data_reg <= m_data_next;
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> !s_ready) else $error("ready during scan");
    a_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        hcnt_reg <= qcnt_reg) else $error("hits exceed lookups");
endmodule

### tb/lru_block_cache_tb.sv
`timescale 1ns / 1ps
module lru_block_cache_tb;
    import lbc_pkg::*;

    localparam int STALL_LIMIT  = 6000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int BEAT_TARGET  = 250;

    typedef enum logic [1:0] {XF_IDLE, XF_WRITE, XF_DISCARD} xfer_mode_t;

    // Tracks the cache contents and predicts every result transaction.
    class cache_scoreboard;
        bit          valid [ENTRIES];
        logic [3:0]  tag_disk [ENTRIES];
        logic [7:0]  tag_block [ENTRIES];
        logic [31:0] stamp [ENTRIES];
        logic [63:0] words [ENTRIES][BLOCK_WORDS];
        logic [31:0] tick, lookups, hits;
        logic [8:0]  entries_reg;
        xfer_mode_t  mode;
        int          slot, wpos;
        status_t     held_status;
        out_item_t   expected_results[$];
        int          mismatches, checked, hit_lookups, miss_lookups, evictions;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                valid[i] = 0; tag_disk[i] = '0; tag_block[i] = '0; stamp[i] = '0;
            end
            tick = '0; lookups = '0; hits = '0; entries_reg = 9'd256;
            mode = XF_IDLE; slot = 0; wpos = 0; held_status = ST_OK;
            mismatches = 0; checked = 0; hit_lookups = 0; miss_lookups = 0; evictions = 0;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 1;
        endfunction

        function int active_entries();
            int n;
            n = entries_reg;
            if (n > ENTRIES) n = ENTRIES;
            if (n < 2) n = 2;
            return n;
        endfunction

        function int find_tag(logic [4:0] d, logic [8:0] b);
            for (int i = 0; i < active_entries(); i++)
                if (valid[i] && {1'b0, tag_disk[i]} == d && {1'b0, tag_block[i]} == b)
                    return i;
            return -1;
        endfunction

        function void queue_result(status_t st, logic [63:0] w, logic last);
            out_item_t r;
            r.status = st; r.read_word = w; r.result_last = last;
            r.query_count = lookups; r.hit_count = hits;
            expected_results.push_back(r);
        endfunction

        function void claim(int i, logic [4:0] d, logic [8:0] b);
            valid[i] = 1; tag_disk[i] = d[3:0]; tag_block[i] = b[7:0];
            tick = bump(tick); stamp[i] = tick;
            slot = i; mode = XF_WRITE;
        endfunction

        function void set_entries(logic [8:0] v);
            entries_reg = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_item(in_item_t it);
            int h, pick;
            bit found;
            if (mode == XF_IDLE) begin
                if (cmd_t'(it.cmd) == CMD_LOOKUP) begin
                    h = find_tag(it.disk, it.block);
                    lookups = bump(lookups);
                    if (h < 0) begin
                        miss_lookups++;
                        queue_result(ST_MISS, '0, 1'b1);
                        return;
                    end
                    hit_lookups++;
                    hits = bump(hits);
                    tick = bump(tick);
                    stamp[h] = tick;
                    for (int k = 0; k < BLOCK_WORDS; k++)
                        queue_result(ST_OK, words[h][k], k == BLOCK_WORDS - 1);
                    return;
                end
                if (cmd_t'(it.cmd) == CMD_NONE) return;
                wpos = 0;
                if (cmd_t'(it.cmd) == CMD_UPDATE) begin
                    h = find_tag(it.disk, it.block);
                    if (h < 0) begin
                        mode = XF_DISCARD; held_status = ST_MISS;
                    end else claim(h, it.disk, it.block);
                end else if (it.disk >= DISK_LIMIT || it.block >= BLOCK_LIMIT) begin
                    mode = XF_DISCARD; held_status = ST_RANGE;
                end else if (find_tag(it.disk, it.block) >= 0) begin
                    mode = XF_DISCARD; held_status = ST_DUP;
                end else begin
                    found = 0; pick = 0;
                    for (int i = 0; i < active_entries(); i++)
                        if (!valid[i]) begin pick = i; found = 1; break; end
                    if (!found) begin
                        evictions++;
                        for (int i = 1; i < active_entries(); i++)
                            if (stamp[i] < stamp[pick]) pick = i;
                    end
                    claim(pick, it.disk, it.block);
                end
            end
            if (mode == XF_WRITE && wpos < BLOCK_WORDS) words[slot][wpos] = it.data_word;
            if (wpos < BLOCK_WORDS) wpos++;
            if (it.word_last) begin
                queue_result((mode == XF_WRITE) ? ST_OK : held_status, '0, 1'b1);
                mode = XF_IDLE; wpos = 0;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result transaction %h", $realtime, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.read_word !== want.read_word ||
                got.result_last !== want.result_last || got.query_count !== want.query_count ||
                got.hit_count !== want.hit_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch: status %0d/%0d word %h/%h last %b/%b qc %0d/%0d hc %0d/%0d (exp/act)",
                             $realtime, want.status, got.status, want.read_word, got.read_word,
                             want.result_last, got.result_last, want.query_count,
                             got.query_count, want.hit_count, got.hit_count);
            end
        endfunction
    endclass

    logic      aclk, aresetn;
    logic      s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    in_item_t  s_data;
    out_item_t m_data;
    logic [8:0] cfg_data;

    cache_scoreboard cache_sb;
    bit quiet, hold_go;
    int beats_sent, stall_count;

    lru_block_cache dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // receiver side, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
            end
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) cache_sb.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_beat(in_item_t it);
        if (!quiet && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cache_sb.note_item(it);
        beats_sent++;
        @(negedge aclk);
    endtask

    // one command: the first beat carries the tag, the rest are data beats
    task automatic run_cmd(cmd_t c, logic [4:0] d, logic [8:0] b, int nbeats);
        in_item_t it;
        for (int k = 0; k < nbeats; k++) begin
            it.cmd       = (k == 0) ? c : 2'($urandom_range(3));
            it.disk      = (k == 0) ? d : 5'($urandom_range(31));
            it.block     = (k == 0) ? b : 9'($urandom_range(511));
            it.data_word = {$urandom, $urandom};
            it.word_last = (k == nbeats - 1) || (c == CMD_LOOKUP) || (c == CMD_NONE);
            push_beat(it);
        end
    endtask

    task automatic write_entries(logic [8:0] v);
        s_valid <= 1'b0;
        while (cache_sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cache_sb.set_entries(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_cmds(int beat_goal);
        int pick;
        logic [4:0] d;
        logic [8:0] b;
        while (beats_sent < beat_goal) begin
            if ($urandom_range(9) == 0) begin
                d = 5'($urandom_range(31)); b = 9'($urandom_range(511));
            end else begin
                d = 5'($urandom_range(2)); b = 9'($urandom_range(5));
            end
            pick = $urandom_range(99);
            // inserts always send the whole block, so no lookup reads an unwritten word
            if (pick < 55)      run_cmd(CMD_LOOKUP, d, b, 1);
            else if (pick < 75) run_cmd(CMD_UPDATE, d, b,
                                        ($urandom_range(3) == 0) ? $urandom_range(30, 36)
                                                                 : $urandom_range(1, 6));
            else if (pick < 95) run_cmd(CMD_INSERT, d, b, BLOCK_WORDS + $urandom_range(0, 3));
            else                run_cmd(CMD_NONE, d, b, 1);
        end
    endtask

    initial begin
        logic [8:0] sizes [7];
        cache_sb = new();
        sizes = '{9'd2, 9'd511, 9'd3, 9'd1, 9'd8, 9'd0, 9'd256};
        aresetn = 1'b0; s_valid = 1'b0; s_data = '0; cfg_valid = 1'b0; cfg_data = '0;
        quiet = 0; hold_go = 0; beats_sent = 0; stall_count = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_entries(9'd256);
        // directed: miss on empty cache, fill, hit, update, every reject case
        run_cmd(CMD_LOOKUP, 5'd0, 9'd0, 1);
        run_cmd(CMD_INSERT, 5'd0, 9'd0, BLOCK_WORDS);
        run_cmd(CMD_LOOKUP, 5'd0, 9'd0, 1);
        run_cmd(CMD_UPDATE, 5'd0, 9'd0, 3);
        run_cmd(CMD_LOOKUP, 5'd0, 9'd0, 1);
        run_cmd(CMD_INSERT, 5'd0, 9'd0, 2);
        run_cmd(CMD_INSERT, 5'd16, 9'd0, 1);
        run_cmd(CMD_INSERT, 5'd0, 9'd256, 2);
        run_cmd(CMD_INSERT, 5'd31, 9'd511, 1);
        run_cmd(CMD_INSERT, 5'd15, 9'd255, BLOCK_WORDS + 4);
        run_cmd(CMD_LOOKUP, 5'd15, 9'd255, 1);
        run_cmd(CMD_UPDATE, 5'd7, 9'd7, 2);
        run_cmd(CMD_NONE, 5'd0, 9'd0, 1);
        run_cmd(CMD_LOOKUP, 5'd31, 9'd511, 1);

        for (int p = 0; p < 7; p++) begin
            write_entries(sizes[p]);
            quiet = (p == 2);
            if (p == 4) begin
                // stall the output while lookups are offered at the input
                run_cmd(CMD_INSERT, 5'd1, 9'd1, BLOCK_WORDS);
                hold_go = 1;
                repeat (6) run_cmd(CMD_LOOKUP, 5'd1, 9'd1, 1);
            end
            random_cmds(beats_sent + BEAT_TARGET / 7);
        end
        quiet = 0;
        s_valid <= 1'b0;
        while (cache_sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("%0d input beats, %0d results checked; lookups %0d hit / %0d miss, %0d evictions",
                 beats_sent, cache_sb.checked, cache_sb.hit_lookups, cache_sb.miss_lookups,
                 cache_sb.evictions);
        $display("entry counts swept from below 2 to above 256, %0d mismatches",
                 cache_sb.mismatches);
        if (cache_sb.mismatches == 0 && cache_sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
